// ----- hw/rtl/tcw_pkg.sv -----
// tcw_pkg: shared constants, codes and types of the text cell terminal writer
// no dependencies; imported by the interfaces and every module of the block but tcw_ram

package tcw_pkg;

  // store geometry
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 32;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int NR_W        = $clog2(MAX_ROWS + 1);

  // transaction field widths
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int CURSOR_W = 13;
  localparam int CELL_W   = 16;

  // register widths and port geometry
  localparam int COLS_REG_W = 8;
  localparam int ROWS_REG_W = 6;
  localparam int COLOUR_W   = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [COLS_REG_W-1:0] COLUMNS_RST = 8'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RST    = 6'd25;
  localparam logic [COLOUR_W-1:0]   FORE_RST    = 4'd7;
  localparam logic [COLOUR_W-1:0]   BACK_RST    = 4'd0;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FORE    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BACK    = 2'd3;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CELL_W-1:0] CELL_BLANK   = 16'h0020;

  // sweep kinds
  localparam int SWK_W = 2;
  localparam logic [SWK_W-1:0] SWK_INIT   = 2'd0;
  localparam logic [SWK_W-1:0] SWK_CLEAR  = 2'd1;
  localparam logic [SWK_W-1:0] SWK_SCROLL = 2'd2;

  typedef struct packed {
    logic [COLS_REG_W-1:0] columns;
    logic [ROWS_REG_W-1:0] rows;
    logic [COLOUR_W-1:0]   fore_colour;
    logic [COLOUR_W-1:0]   back_colour;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic             latch_in;
    logic             calc_addr;
    logic             put;
    logic             cval;
    logic             sweep_start;
    logic [SWK_W-1:0] sweep_kind;
    logic             sweep_step;
    logic             read_issue;
    logic             out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scroll;
    logic            sweep_done;
  } stat_t;

endpackage

// ----- hw/rtl/tcw_in_if.sv -----
// tcw_in_if: input channel carrying one request transaction
// depends on tcw_pkg for field widths

interface tcw_in_if;
  import tcw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [CHAR_W-1:0]    char_code;
  logic [INDEX_W-1:0]   cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input operation, input char_code, input cell_index,
                  output ready);
endinterface

// ----- hw/rtl/tcw_out_if.sv -----
// tcw_out_if: result channel carrying one result transaction
// depends on tcw_pkg for field widths

interface tcw_out_if;
  import tcw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CURSOR_W-1:0]  cursor_index;
  logic [CELL_W-1:0]    read_cell;

  modport source (output valid, output cursor_index, output read_cell, input ready);
  modport sink   (input valid, input cursor_index, input read_cell, output ready);
endinterface

// ----- hw/rtl/tcw_ram.sv -----
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tcw_cfg.sv -----
// tcw_cfg: apb-style configuration registers (columns, rows, colours)
// depends on tcw_pkg

module tcw_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output tcw_pkg::cfg_t                     cfg
);
  import tcw_pkg::*;

  logic [COLS_REG_W-1:0] columns_r;
  logic [ROWS_REG_W-1:0] rows_r;
  logic [COLOUR_W-1:0]   fore_r;
  logic [COLOUR_W-1:0]   back_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
      fore_r    <= FORE_RST;
      back_r    <= BACK_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COLUMNS: columns_r <= pwdata[COLS_REG_W-1:0];
        REG_ROWS:    rows_r    <= pwdata[ROWS_REG_W-1:0];
        REG_FORE:    fore_r    <= pwdata[COLOUR_W-1:0];
        REG_BACK:    back_r    <= pwdata[COLOUR_W-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_COLUMNS: prdata = CFG_DATA_W'(columns_r);
      REG_ROWS:    prdata = CFG_DATA_W'(rows_r);
      REG_FORE:    prdata = CFG_DATA_W'(fore_r);
      REG_BACK:    prdata = CFG_DATA_W'(back_r);
    endcase
  end

  assign cfg.columns     = columns_r;
  assign cfg.rows        = rows_r;
  assign cfg.fore_colour = fore_r;
  assign cfg.back_colour = back_r;

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// tcw_ctrl: sequencing state machine of the terminal writer
// depends on tcw_pkg; drives cmd_t to the datapath and reads stat_t back

module tcw_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [tcw_pkg::OP_W-1:0]  in_operation,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tcw_pkg::cmd_t             cmd,
  input  tcw_pkg::stat_t            stat
);
  import tcw_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_ISET   = 4'd0;
  localparam logic [ST_W-1:0] ST_ISWEEP = 4'd1;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd2;
  localparam logic [ST_W-1:0] ST_ADDR   = 4'd3;
  localparam logic [ST_W-1:0] ST_PUT    = 4'd4;
  localparam logic [ST_W-1:0] ST_CVAL   = 4'd5;
  localparam logic [ST_W-1:0] ST_SWSET  = 4'd6;
  localparam logic [ST_W-1:0] ST_SWEEP  = 4'd7;
  localparam logic [ST_W-1:0] ST_RD     = 4'd8;
  localparam logic [ST_W-1:0] ST_FIN    = 4'd9;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_ISET: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep_kind  = SWK_INIT;
        state_nxt       = ST_ISWEEP;
      end
      ST_ISWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (in_operation)
            OP_PUT:   state_nxt = ST_ADDR;
            OP_READ:  state_nxt = ST_RD;
            OP_CLEAR: state_nxt = ST_SWSET;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = ST_PUT;
      end
      ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = ST_CVAL;
      end
      ST_CVAL: begin
        cmd.cval  = 1'b1;
        state_nxt = stat.scroll ? ST_SWSET : ST_FIN;
      end
      ST_SWSET: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep_kind  = (stat.op == OP_CLEAR) ? SWK_CLEAR : SWK_SCROLL;
        state_nxt       = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_RD: begin
        cmd.read_issue = 1'b1;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ISET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/tcw_dp.sv -----
// tcw_dp: datapath - cursor arithmetic, cell store, sweep engine, result register
// depends on tcw_pkg and tcw_ram; steered by cmd_t from tcw_ctrl

module tcw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::cfg_t                 cfg,
  input  tcw_pkg::cmd_t                 cmd,
  output tcw_pkg::stat_t                stat,
  input  logic [tcw_pkg::OP_W-1:0]      in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  output logic [tcw_pkg::CURSOR_W-1:0]  out_cursor_index,
  output logic [tcw_pkg::CELL_W-1:0]    out_read_cell
);
  import tcw_pkg::*;

  // latched transaction
  logic [OP_W-1:0]     op_r;
  logic [CHAR_W-1:0]   ch_r;
  logic [INDEX_W-1:0]  idx_r;

  // cursor state
  logic [ROW_W-1:0]    cur_row_r;
  logic [COL_W-1:0]    cur_col_r;
  logic [CURSOR_W-1:0] cur_val_r;

  // effective geometry and attribute
  logic [COL_W-1:0]    nc;
  logic [NR_W-1:0]     nr;
  logic [CELL_W-1:0]   attr_space;
  logic [CELL_W-1:0]   attr_char;
  logic                is_bs;
  logic                is_nl;

  // address step
  logic [ROW_W-1:0]    r_cl, rw_v, rw_r;
  logic [COL_W-1:0]    c_cl, cw_v, cw_r;
  logic [CNT_W-1:0]    base_v;
  logic [ADDR_W-1:0]   base_r;

  // put step
  logic [COL_W:0]      c_inc;
  logic [NR_W-1:0]     r_n;
  logic [COL_W-1:0]    c_n;
  logic                scroll_v;
  logic [ROW_W-1:0]    rfin_v, rfin_r;
  logic [COL_W-1:0]    cfin_r;
  logic                plus1_r;
  logic                scroll_r;

  // sweep engine
  logic [CNT_W-1:0]    k_r;
  logic [CNT_W-1:0]    limit_r;
  logic                copy_r;
  logic [CELL_W-1:0]   fill_r;
  logic                pend_v_r;
  logic                pend_copy_r;
  logic [ADDR_W-1:0]   pend_addr_r;
  logic [CNT_W-1:0]    src_v;
  logic                in_range;
  logic                issue_v;
  logic                src_ok;

  // cell store ports
  logic                we;
  logic [ADDR_W-1:0]   wr_addr;
  logic [CELL_W-1:0]   wr_data;
  logic                re;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CELL_W-1:0]   rd_data;

  // result register
  logic [CURSOR_W-1:0] out_cur_r;
  logic [CELL_W-1:0]   out_rd_r;

  // saturated geometry
  always_comb begin
    if (cfg.columns == '0) begin
      nc = COL_W'(1);
    end else if (cfg.columns > COLS_REG_W'(MAX_COLUMNS)) begin
      nc = COL_W'(MAX_COLUMNS);
    end else begin
      nc = COL_W'(cfg.columns);
    end
    if (cfg.rows == '0) begin
      nr = NR_W'(1);
    end else if (cfg.rows > ROWS_REG_W'(MAX_ROWS)) begin
      nr = NR_W'(MAX_ROWS);
    end else begin
      nr = NR_W'(cfg.rows);
    end
  end

  assign attr_space = {cfg.back_colour, cfg.fore_colour, CH_SPACE};
  assign attr_char  = {cfg.back_colour, cfg.fore_colour, ch_r};
  assign is_bs      = (ch_r == CH_BACKSPACE);
  assign is_nl      = (ch_r == CH_NEWLINE);

  // transaction latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_operation;
      ch_r  <= in_char_code;
      idx_r <= in_cell_index;
    end
  end

  // clamp cursor into the area in use, step back for backspace, form cell address
  always_comb begin
    r_cl = (NR_W'(cur_row_r) > nr - NR_W'(1)) ? ROW_W'(nr - NR_W'(1)) : cur_row_r;
    c_cl = (cur_col_r > nc - COL_W'(1)) ? (nc - COL_W'(1)) : cur_col_r;
    rw_v = r_cl;
    cw_v = c_cl;
    if (is_bs) begin
      if (c_cl == '0) begin
        if (r_cl != '0) begin
          rw_v = r_cl - ROW_W'(1);
          cw_v = nc - COL_W'(1);
        end
      end else begin
        cw_v = c_cl - COL_W'(1);
      end
    end
    base_v = CNT_W'(rw_v) * CNT_W'(nc) + CNT_W'(cw_v);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_addr) begin
      rw_r   <= rw_v;
      cw_r   <= cw_v;
      base_r <= base_v[ADDR_W-1:0];
    end
  end

  // advance the cursor after the cell write, detect scroll
  always_comb begin
    c_inc = {1'b0, cw_r} + (COL_W+1)'(1);
    r_n   = NR_W'(rw_r);
    c_n   = cw_r;
    if (is_nl) begin
      c_n = '0;
      r_n = NR_W'(rw_r) + NR_W'(1);
    end else if (!is_bs) begin
      if (c_inc >= {1'b0, nc}) begin
        c_n = '0;
        r_n = NR_W'(rw_r) + NR_W'(1);
      end else begin
        c_n = c_inc[COL_W-1:0];
      end
    end
    scroll_v = !is_bs && (r_n >= nr);
    rfin_v   = scroll_v ? ROW_W'(nr - NR_W'(1)) : r_n[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= 1'b0;
    end else if (cmd.put) begin
      scroll_r <= scroll_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      rfin_r  <= rfin_v;
      cfin_r  <= c_n;
      plus1_r <= !is_bs;
    end
  end

  // cursor registers: commit after a put, home on clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      cur_val_r <= '0;
    end else if (cmd.cval) begin
      cur_row_r <= rfin_r;
      cur_col_r <= cfin_r;
      cur_val_r <= CURSOR_W'(rfin_r) * CURSOR_W'(nc) + CURSOR_W'(cfin_r)
                   + CURSOR_W'(plus1_r);
    end else if (cmd.sweep_start && (cmd.sweep_kind == SWK_CLEAR)) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      cur_val_r <= CURSOR_W'(nc) + CURSOR_W'(1);
    end
  end

  // sweep engine: one cell a cycle, copy from one row below or fill
  assign in_range = (k_r < limit_r);
  assign issue_v  = cmd.sweep_step && in_range;
  assign src_v    = k_r + CNT_W'(nc);
  assign src_ok   = copy_r && (src_v < limit_r);

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      k_r     <= '0;
      limit_r <= (cmd.sweep_kind == SWK_INIT) ? CNT_W'(STORE_DEPTH)
                                              : CNT_W'(nr) * CNT_W'(nc);
      copy_r  <= (cmd.sweep_kind == SWK_SCROLL);
      fill_r  <= (cmd.sweep_kind == SWK_SCROLL) ? attr_space : CELL_BLANK;
    end else if (issue_v) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= issue_v;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_v) begin
      pend_copy_r <= src_ok;
      pend_addr_r <= k_r[ADDR_W-1:0];
    end
  end

  // store port steering
  always_comb begin
    re      = cmd.read_issue || (issue_v && src_ok);
    rd_addr = cmd.read_issue ? idx_r : src_v[ADDR_W-1:0];
    if (pend_v_r) begin
      we      = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = pend_copy_r ? rd_data : fill_r;
    end else begin
      we      = cmd.put && !is_nl;
      wr_addr = base_r;
      wr_data = is_bs ? attr_space : attr_char;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .re      (re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cur_r <= cur_val_r;
      out_rd_r  <= (op_r == OP_READ) ? rd_data : '0;
    end
  end

  assign out_cursor_index = out_cur_r;
  assign out_read_cell    = out_rd_r;

  assign stat.op         = op_r;
  assign stat.scroll     = scroll_r;
  assign stat.sweep_done = !in_range && !pend_v_r;

endmodule

// ----- hw/rtl/text_cell_terminal_writer_unit.sv -----
// text_cell_terminal_writer_unit: top level of the text cell terminal writer
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_cfg, tcw_ctrl, tcw_dp
//
//   channel   direction  handshake              payload
//   in_item   in         valid / ready          operation, char_code, cell_index
//   out_item  out        valid / ready          cursor_index, read_cell
//   cfg_*     in         apb write, pready = 1  columns, rows, fore/back colour
//
// one transaction at a time; from acceptance to result in the output register
// a put steps through address, put, cursor and finish, a read through read and
// finish, an unknown operation through finish alone, each then back to idle;
// a put that scrolls adds a sweep of rows*columns cells and a clear is one, at
// one cell per cycle on the single store write port; after reset a clearing pass
// writes all 4096 cells, in_ready low; an unread result stalls only the next finish

module text_cell_terminal_writer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  tcw_in_if.sink                           in_item,
  tcw_out_if.source                        out_item,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import tcw_pkg::*;

  cfg_t                cfg;
  cmd_t                cmd;
  stat_t               stat;
  logic                in_ready;
  logic                out_valid;
  logic [CURSOR_W-1:0] cursor_index;
  logic [CELL_W-1:0]   read_cell;

  // configuration registers
  tcw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer
  tcw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_item.valid),
    .in_operation (in_item.operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_item.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // datapath and cell store
  tcw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_item.operation),
    .in_char_code     (in_item.char_code),
    .in_cell_index    (in_item.cell_index),
    .out_cursor_index (cursor_index),
    .out_read_cell    (read_cell)
  );

  assign in_item.ready         = in_ready;
  assign out_item.valid        = out_valid;
  assign out_item.cursor_index = cursor_index;
  assign out_item.read_cell    = read_cell;

`ifndef SYNTHESIS
  // only one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  // no store writes or sweeps while waiting for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!cmd.sweep_step && !cmd.put && !cmd.sweep_start))
    else $error("store activity while idle");

  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_item.ready))
    else $error("result register overwritten");

  // a loaded result is offered next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not offered");
`endif

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench of the text cell terminal writer unit
// drives put, read, clear and unknown requests with random idling on both channels,
// predicts cursor and cell values internally; depends on tcw_pkg, tcw_in_if, tcw_out_if

`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_index;
    logic [CELL_W-1:0]   read_cell;
  } cursor_read_t;

  // operation code with no meaning to the block
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tcw_in_if  in_bus();
  tcw_out_if out_bus();

  text_cell_terminal_writer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_bus),
    .out_item    (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the terminal state and its registers
  logic [CELL_W-1:0]     screen_cells [STORE_DEPTH];
  int                    cur_row;
  int                    cur_col;
  logic [CURSOR_W-1:0]   cursor_pos;
  logic [COLS_REG_W-1:0] reg_columns;
  logic [ROWS_REG_W-1:0] reg_rows;
  logic [COLOUR_W-1:0]   reg_fore;
  logic [COLOUR_W-1:0]   reg_back;

  cursor_read_t pending_cursor_reads [$];
  int           mismatch_count;
  bit           no_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int eff_columns();
    if (int'(reg_columns) == 0) return 1;
    if (int'(reg_columns) > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(reg_columns);
  endfunction

  function automatic int eff_rows();
    if (int'(reg_rows) == 0) return 1;
    if (int'(reg_rows) > MAX_ROWS) return MAX_ROWS;
    return int'(reg_rows);
  endfunction

  // one request applied to the shadow state, giving the expected result
  function automatic cursor_read_t terminal_step(input logic [OP_W-1:0] op,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [INDEX_W-1:0] idx);
    cursor_read_t res;
    int nc;
    int nr;
    int r;
    int c;
    logic [7:0] attr;
    nc = eff_columns();
    nr = eff_rows();
    attr = {reg_back, reg_fore};
    res.read_cell = '0;
    case (op)
      OP_PUT: begin
        r = (cur_row > nr - 1) ? nr - 1 : cur_row;
        c = (cur_col > nc - 1) ? nc - 1 : cur_col;
        if (ch == CH_BACKSPACE) begin
          // step back, wrapping to the end of the previous row
          if (c == 0 && r > 0) begin
            r--;
            c = nc;
          end
          if (c > 0) c--;
          screen_cells[r * nc + c] = {attr, CH_SPACE};
          cursor_pos = CURSOR_W'(r * nc + c);
        end else begin
          if (ch == CH_NEWLINE) begin
            c = 0;
            r++;
          end else begin
            screen_cells[r * nc + c] = {attr, ch};
            c++;
            if (c >= nc) begin
              c = 0;
              r++;
            end
          end
          // scroll up past the last row
          if (r >= nr) begin
            for (int y = 1; y < nr; y++)
              for (int x = 0; x < nc; x++)
                screen_cells[(y - 1) * nc + x] = screen_cells[y * nc + x];
            for (int x = 0; x < nc; x++)
              screen_cells[(nr - 1) * nc + x] = {attr, CH_SPACE};
            r = nr - 1;
          end
          cursor_pos = CURSOR_W'(r * nc + c + 1);
        end
        cur_row = r;
        cur_col = c;
      end
      OP_READ: res.read_cell = screen_cells[idx];
      OP_CLEAR: begin
        for (int i = 0; i < nc * nr; i++) screen_cells[i] = CELL_BLANK;
        cur_row = 0;
        cur_col = 0;
        cursor_pos = CURSOR_W'(nc + 1);
      end
      default: ;
    endcase
    res.cursor_index = cursor_pos;
    return res;
  endfunction

  // result receiver with random stalls
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    cursor_read_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_cursor_reads.size() == 0) begin
        $error("unexpected transaction: cursor_index %0d read_cell 0x%04h",
               out_bus.cursor_index, out_bus.read_cell);
        mismatch_count++;
      end else begin
        want = pending_cursor_reads.pop_front();
        if (out_bus.cursor_index !== want.cursor_index) begin
          $error("cursor_index: expected %0d, actual %0d",
                 want.cursor_index, out_bus.cursor_index);
          mismatch_count++;
        end
        if (out_bus.read_cell !== want.read_cell) begin
          $error("read_cell: expected 0x%04h, actual 0x%04h",
                 want.read_cell, out_bus.read_cell);
          mismatch_count++;
        end
      end
    end
  end

  // one request transaction; entered and left at a falling edge
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.char_code  <= ch;
    in_bus.cell_index <= idx;
    do @(posedge clk); while (!in_bus.ready);
    pending_cursor_reads.push_back(terminal_step(op, ch, idx));
    @(negedge clk);
  endtask

  // hold off until every result is back and the block is idle again
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (pending_cursor_reads.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // apb write: setup then access cycle
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_COLUMNS: reg_columns = value[COLS_REG_W-1:0];
      REG_ROWS:    reg_rows    = value[ROWS_REG_W-1:0];
      REG_FORE:    reg_fore    = value[COLOUR_W-1:0];
      REG_BACK:    reg_back    = value[COLOUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // all four registers, with noise in the unused upper bits
  task automatic set_geometry(input int cols, input int rws, input int fore, input int back);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom();
    write_register(REG_COLUMNS, {noise[31:8], 8'(cols)});
    write_register(REG_ROWS, {noise[31:6], 6'(rws)});
    write_register(REG_FORE, {noise[31:4], 4'(fore)});
    write_register(REG_BACK, {~noise[31:4], 4'(back)});
  endtask

  // reads of the blank store and an unknown operation
  task automatic test_reset_reads();
    send_request(OP_READ, 8'h00, 12'd0);
    send_request(OP_READ, 8'hFF, 12'hFFF);
    send_request(OP_UNUSED, 8'h5A, 12'hA5A);
  endtask

  // backspace at home, extreme bytes, newline, backspace across a row
  task automatic test_put_codes();
    send_request(OP_PUT, CH_BACKSPACE, 12'd0);
    send_request(OP_PUT, 8'h41, 12'd0);
    send_request(OP_PUT, 8'hFF, 12'hFFF);
    send_request(OP_PUT, 8'h00, 12'd0);
    send_request(OP_PUT, CH_NEWLINE, 12'd0);
    send_request(OP_PUT, CH_BACKSPACE, 12'd0);
    send_request(OP_READ, 8'h00, 12'd79);
    send_request(OP_READ, 8'h00, 12'd1);
  endtask

  task automatic test_clear();
    send_request(OP_CLEAR, 8'h00, 12'd0);
    send_request(OP_READ, 8'h00, 12'd1);
  endtask

  // tiny screen: wrap at the row end and scroll at the last row
  task automatic test_wrap_and_scroll();
    wait_for_results();
    set_geometry(2, 2, 15, 15);
    send_request(OP_PUT, 8'h78, 12'd0);
    send_request(OP_PUT, 8'h79, 12'd0);
    send_request(OP_PUT, 8'h7A, 12'd0);
    send_request(OP_PUT, 8'h77, 12'd0);
    send_request(OP_READ, 8'h00, 12'd0);
    send_request(OP_READ, 8'h00, 12'd2);
  endtask

  // zero registers saturate to one cell; cursor pulled back inside
  task automatic test_saturation();
    wait_for_results();
    set_geometry(0, 0, 10, 5);
    send_request(OP_PUT, 8'h71, 12'd0);
    send_request(OP_READ, 8'h00, 12'd0);
    send_request(OP_PUT, CH_BACKSPACE, 12'd0);
  endtask

  // one setting of the registers followed by mostly well-formed text
  task automatic run_phase(input int cols, input int rws, input int n_items,
                           input int nl_pct);
    int p;
    int span;
    logic [CHAR_W-1:0] ch;
    logic [INDEX_W-1:0] idx;
    wait_for_results();
    set_geometry(cols, rws, $urandom_range(15), $urandom_range(15));
    span = eff_columns() * eff_rows();
    for (int i = 0; i < n_items; i++) begin
      p   = $urandom_range(99);
      idx = INDEX_W'($urandom_range(STORE_DEPTH - 1));
      ch  = ($urandom_range(3) == 0) ? CHAR_W'($urandom_range(255))
                                     : CHAR_W'($urandom_range(8'h7E, 8'h20));
      if (p < nl_pct) send_request(OP_PUT, CH_NEWLINE, idx);
      else if (p < nl_pct + 45) send_request(OP_PUT, ch, idx);
      else if (p < nl_pct + 53) send_request(OP_PUT, CH_BACKSPACE, idx);
      else if (p < 97) begin
        if ($urandom_range(9) < 7) idx = INDEX_W'($urandom_range(span - 1));
        send_request(OP_READ, ch, idx);
      end
      else if (p < 99) send_request(OP_CLEAR, ch, idx);
      else send_request(OP_UNUSED, ch, idx);
      // now and then let the block run dry
      if ($urandom_range(199) == 0) wait_for_results();
    end
  endtask

  task automatic test_random_traffic();
    run_phase($urandom_range(16, 1), $urandom_range(8, 1), 155, 10);
    run_phase(MAX_COLUMNS, MAX_ROWS, 70, 35);
    run_phase(255, 63, 70, 35);
    run_phase(0, 0, 155, 10);
    run_phase(1, MAX_ROWS, 155, 10);
    run_phase(MAX_COLUMNS, 1, 155, 10);
    // long stretch without idling on either side
    no_idle = 1'b1;
    run_phase($urandom_range(16, 1), $urandom_range(8, 1), 155, 10);
    no_idle = 1'b0;
    for (int k = 0; k < 7; k++)
      run_phase($urandom_range(16, 1), $urandom_range(8, 1), 155, 10);
  endtask

  // reset, tests in turn, then drain and verdict
  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) screen_cells[i] = CELL_BLANK;
    cur_row           = 0;
    cur_col           = 0;
    cursor_pos        = '0;
    reg_columns       = COLUMNS_RST;
    reg_rows          = ROWS_RST;
    reg_fore          = FORE_RST;
    reg_back          = BACK_RST;
    mismatch_count    = 0;
    no_idle           = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_PUT;
    in_bus.char_code  = '0;
    in_bus.cell_index = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);

    test_reset_reads();
    test_put_codes();
    test_clear();
    test_wrap_and_scroll();
    test_saturation();
    test_random_traffic();

    in_bus.valid <= 1'b0;
    for (int n = 0; n < 200000 && pending_cursor_reads.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_cursor_reads.size() != 0) begin
      $error("%0d expected transactions never arrived", pending_cursor_reads.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
